// ===== rtl/mfsgd_pkg.sv =====
// Shared types, constants and arithmetic helpers for the rating-update block.
package mfsgd_pkg;

    localparam int MAX_FACTORS_DEF = 32;
    localparam int NUM_USERS_DEF   = 4096;
    localparam int NUM_MOVIES_DEF  = 8192;

    localparam logic [14:0] PRED_LOW  = 15'd2048;
    localparam logic [14:0] PRED_HIGH = 15'd20480;

    localparam logic [1:0] CMD_LOAD_USER  = 2'd0;
    localparam logic [1:0] CMD_LOAD_MOVIE = 2'd1;
    localparam logic [1:0] CMD_TRAIN      = 2'd2;
    localparam logic [1:0] CMD_PREDICT    = 2'd3;

    localparam logic [1:0] REG_GLOBAL_MEAN = 2'd0;
    localparam logic [1:0] REG_LEARN_RATE  = 2'd1;
    localparam logic [1:0] REG_REG_WEIGHT  = 2'd2;
    localparam logic [1:0] REG_FACTORS     = 2'd3;

    localparam logic [15:0] LEARN_RATE_RST = 16'd328;
    localparam logic [15:0] REG_WEIGHT_RST = 16'd1311;
    localparam logic [5:0]  FACTORS_RST    = 6'd32;

    typedef struct packed {
        logic [14:0] global_mean;
        logic [15:0] learn_rate;
        logic [15:0] reg_weight;
        logic [5:0]  factors_in_use;
    } t_cfg;

    // Saturates a wide signed value to 16 signed bits.
    function automatic logic signed [15:0] sat16(input logic signed [49:0] v);
        logic signed [15:0] r;
        if (v > 50'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -50'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/mfsgd_ram.sv =====
// Generic single-port synchronous RAM with registered read.
module mfsgd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/mfsgd_step.sv =====
// SGD step unit: registered term and product multiply stages, then a scaled add with saturation.
module mfsgd_step
    import mfsgd_pkg::*;
(
    input  logic               i_clk,
    input  logic signed [15:0] i_self,
    input  logic signed [34:0] i_grad,
    input  logic        [15:0] i_learn_rate,
    input  logic        [15:0] i_reg_weight,
    output logic signed [15:0] o_new
);

    // Stage 1: term = grad - lambda * self (grad already at 16 fraction-bit scale).
    logic signed [35:0] r_term;
    logic signed [15:0] r_self;
    logic signed [15:0] r_self2;
    logic signed [51:0] r_prod;
    logic signed [35:0] n_term;

    assign n_term = 36'(i_grad) - 36'($signed({1'b0, i_reg_weight}) * i_self);

    always_ff @(posedge i_clk) begin
        r_term  <= n_term;
        r_self  <= i_self;
        r_prod  <= 52'($signed({1'b0, i_learn_rate}) * r_term);
        r_self2 <= r_self;
    end

    assign o_new = sat16(50'(r_self2) + 50'(r_prod >>> 32));

endmodule

// ===== rtl/mf_sgd_rating_update.sv =====
// Top level of the biased matrix-factorization SGD rating engine.
// Usage: input beats arrive on the s_axis group; tdata carries cmd, user_index,
// movie_index, factor_index, load_value and rating packed from bit 0 up.
// Load commands write one factor element and give no result. Train and predict
// give one result beat on m_axis: prediction, error, was_training.
// Configuration writes use i_cfg_valid/o_cfg_ready with a register index.
// A load is written at its input beat and the next beat can be taken in the
// following cycle. A train or predict item is finished before the next beat is
// accepted. Its duration is set by the single port of each factor memory,
// walked once for the dot product and once for the read-modify-write update,
// where each factor passes through the step pipeline.
// After reset the block clears every row of both bias tables, one row per cycle,
// and accepts no beat meanwhile.
// The result waits in an output register; while the receiver stalls the
// block holds it and accepts no new item.
module mf_sgd_rating_update
    import mfsgd_pkg::*;
#(
    parameter int MAX_FACTORS = MAX_FACTORS_DEF,
    parameter int NUM_USERS   = NUM_USERS_DEF,
    parameter int NUM_MOVIES  = NUM_MOVIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd[1:0], user_index[13:2], movie_index[26:14], factor_index[31:27],
    // load_value[47:32], rating[62:48], zero[63]
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // prediction[14:0], error[30:15], zero[31]
    output logic [31:0] m_axis_tdata,
    // was_training
    output logic        m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int UW = $clog2(NUM_USERS);
    localparam int MW = $clog2(NUM_MOVIES);
    localparam int FW = (MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1;
    localparam int KW = $clog2(MAX_FACTORS + 1);
    localparam int CW = (UW > MW) ? UW + 1 : MW + 1;
    localparam int UD = NUM_USERS * (2 ** FW);
    localparam int MD = NUM_MOVIES * (2 ** FW);
    localparam int UAW = $clog2(UD);
    localparam int MAW = $clog2(MD);
    localparam int URS = 16 + UW;
    localparam int MRS = 16 + MW;
    localparam logic [17:0] URM =
        18'(((64'd1 << URS) + 64'(NUM_USERS) - 64'd1) / 64'(NUM_USERS));
    localparam logic [17:0] MRM =
        18'(((64'd1 << MRS) + 64'(NUM_MOVIES) - 64'd1) / 64'(NUM_MOVIES));

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_BIAS, S_DOT, S_SUM, S_UPD_RD, S_UPD_WAIT,
        S_UPD_MUL, S_UPD_WR, S_OUT
    } t_state;

    t_state r_state;
    t_cfg   r_cfg;

    logic [1:0]  in_cmd;
    logic [15:0] in_uidx, in_midx;
    logic [4:0]  in_fidx;
    logic [15:0] in_load;
    logic [14:0] in_rating;
    assign in_cmd    = s_axis_tdata[1:0];
    assign in_uidx   = {4'd0, s_axis_tdata[13:2]};
    assign in_midx   = {3'd0, s_axis_tdata[26:14]};
    assign in_fidx   = s_axis_tdata[31:27];
    assign in_load   = s_axis_tdata[47:32];
    assign in_rating = s_axis_tdata[62:48];

    logic [UW-1:0] r_u;
    logic [MW-1:0] r_m;
    logic          r_train;
    logic [14:0]   r_rating;
    logic [KW-1:0] r_k, r_kk;
    logic [CW-1:0] r_clr;
    logic signed [15:0] r_ub, r_mb, r_p, r_q;
    logic signed [47:0] r_acc;
    logic signed [15:0] r_err;
    logic [14:0]   r_pred;
    logic [1:0]    r_phase;
    logic          r_dv;

    // Memories.
    logic           uf_we, mf_we, ub_we, mb_we;
    logic [UAW-1:0] uf_addr;
    logic [MAW-1:0] mf_addr;
    logic [UW-1:0]  ub_addr;
    logic [MW-1:0]  mb_addr;
    logic [15:0]    uf_wd, mf_wd, ub_wd, mb_wd, uf_rd, mf_rd, ub_rd, mb_rd;

    mfsgd_ram #(.WIDTH(16), .DEPTH(UD)) u_uf (
        .i_clk(i_clk), .i_we(uf_we), .i_addr(uf_addr), .i_wdata(uf_wd), .o_rdata(uf_rd));
    mfsgd_ram #(.WIDTH(16), .DEPTH(MD)) u_mf (
        .i_clk(i_clk), .i_we(mf_we), .i_addr(mf_addr), .i_wdata(mf_wd), .o_rdata(mf_rd));
    mfsgd_ram #(.WIDTH(16), .DEPTH(NUM_USERS)) u_ub (
        .i_clk(i_clk), .i_we(ub_we), .i_addr(ub_addr), .i_wdata(ub_wd), .o_rdata(ub_rd));
    mfsgd_ram #(.WIDTH(16), .DEPTH(NUM_MOVIES)) u_mb (
        .i_clk(i_clk), .i_we(mb_we), .i_addr(mb_addr), .i_wdata(mb_wd), .o_rdata(mb_rd));

    // Step units: user side and movie side share the pair for biases and factors.
    logic signed [15:0] su_self, sm_self, su_new, sm_new;
    logic signed [34:0] su_grad, sm_grad;
    logic signed [31:0] r_eq, r_ep;

    mfsgd_step u_step_u (
        .i_clk(i_clk), .i_self(su_self), .i_grad(su_grad),
        .i_learn_rate(r_cfg.learn_rate), .i_reg_weight(r_cfg.reg_weight), .o_new(su_new));
    mfsgd_step u_step_m (
        .i_clk(i_clk), .i_self(sm_self), .i_grad(sm_grad),
        .i_learn_rate(r_cfg.learn_rate), .i_reg_weight(r_cfg.reg_weight), .o_new(sm_new));

    logic         in_fire;
    logic [FW-1:0] k_idx;
    logic          is_bias_phase;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign k_idx = r_k[FW-1:0];
    assign is_bias_phase = (r_phase == 2'd0);

    // Row indexes are reduced modulo the table sizes by reciprocal multiplication.
    logic [33:0]   u_mul, m_mul;
    logic [15:0]   u_quo, m_quo;
    logic [UW-1:0] ld_u;
    logic [MW-1:0] ld_m;
    logic [FW-1:0] ld_f;
    assign u_mul = 34'(in_uidx) * 34'(URM);
    assign m_mul = 34'(in_midx) * 34'(MRM);
    assign u_quo = 16'(u_mul >> URS);
    assign m_quo = 16'(m_mul >> MRS);
    assign ld_u = UW'(32'(in_uidx) - 32'(u_quo) * 32'(NUM_USERS));
    assign ld_m = MW'(32'(in_midx) - 32'(m_quo) * 32'(NUM_MOVIES));
    assign ld_f = FW'(in_fidx);

    // Gradient inputs: bias uses err<<16; factors use err*other<<4.
    always_comb begin
        if (is_bias_phase) begin
            su_self = r_ub;
            sm_self = r_mb;
            su_grad = 35'($signed({r_err, 16'd0}));
            sm_grad = 35'($signed({r_err, 16'd0}));
        end else begin
            su_self = r_p;
            sm_self = r_q;
            su_grad = 35'(r_eq) <<< 4;
            sm_grad = 35'(r_ep) <<< 4;
        end
    end

    always_comb begin
        uf_we = 1'b0; mf_we = 1'b0; ub_we = 1'b0; mb_we = 1'b0;
        uf_wd = in_load; mf_wd = in_load;
        ub_wd = 16'd0; mb_wd = 16'd0;
        uf_addr = UAW'({ld_u, ld_f});
        mf_addr = MAW'({ld_m, ld_f});
        ub_addr = r_u; mb_addr = r_m;
        case (r_state)
            S_CLEAR: begin
                ub_addr = r_clr[UW-1:0];
                mb_addr = r_clr[MW-1:0];
                ub_we = (r_clr < CW'(NUM_USERS));
                mb_we = (r_clr < CW'(NUM_MOVIES));
            end
            S_IDLE: begin
                ub_addr = ld_u;
                mb_addr = ld_m;
                if (in_fire && 32'(in_fidx) < MAX_FACTORS) begin
                    uf_we = (in_cmd == CMD_LOAD_USER);
                    mf_we = (in_cmd == CMD_LOAD_MOVIE);
                end
            end
            S_DOT, S_UPD_RD, S_UPD_WAIT, S_UPD_MUL: begin
                uf_addr = UAW'({r_u, k_idx});
                mf_addr = MAW'({r_m, k_idx});
            end
            S_UPD_WR: begin
                uf_addr = UAW'({r_u, k_idx});
                mf_addr = MAW'({r_m, k_idx});
                uf_wd = su_new; mf_wd = sm_new;
                if (is_bias_phase) begin
                    ub_we = 1'b1; mb_we = 1'b1;
                    ub_wd = su_new; mb_wd = sm_new;
                end else begin
                    uf_we = 1'b1; mf_we = 1'b1;
                end
            end
            default: ;
        endcase
    end

    logic signed [31:0] prod;
    assign prod = $signed(uf_rd) * $signed(mf_rd);

    function automatic logic signed [47:0] sum_pred_low();
        return 48'(PRED_LOW) <<< 12;
    endfunction
    function automatic logic signed [47:0] sum_pred_high();
        return 48'(PRED_HIGH) <<< 12;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_cfg <= '{global_mean: 15'd0, learn_rate: LEARN_RATE_RST,
                       reg_weight: REG_WEIGHT_RST, factors_in_use: FACTORS_RST};
            m_axis_tvalid <= 1'b0;
            r_dv <= 1'b0;
            r_phase <= 2'd0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_GLOBAL_MEAN: r_cfg.global_mean <= i_cfg_data[14:0];
                    REG_LEARN_RATE:  r_cfg.learn_rate <= i_cfg_data;
                    REG_REG_WEIGHT:  r_cfg.reg_weight <= i_cfg_data;
                    REG_FACTORS:     r_cfg.factors_in_use <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr >= CW'(NUM_USERS - 1) && r_clr >= CW'(NUM_MOVIES - 1))
                        r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (in_fire && (in_cmd == CMD_TRAIN || in_cmd == CMD_PREDICT)) begin
                        r_u <= ld_u;
                        r_m <= ld_m;
                        r_train <= (in_cmd == CMD_TRAIN);
                        r_rating <= in_rating;
                        r_kk <= (32'(r_cfg.factors_in_use) > MAX_FACTORS) ?
                                KW'(MAX_FACTORS) : KW'(r_cfg.factors_in_use);
                        r_k <= '0;
                        r_state <= S_BIAS;
                    end
                end
                S_BIAS: begin
                    r_ub <= ub_rd;
                    r_mb <= mb_rd;
                    r_acc <= (48'($signed({1'b0, r_cfg.global_mean})) + 48'($signed(ub_rd))
                              + 48'($signed(mb_rd))) <<< 12;
                    r_dv <= 1'b0;
                    r_state <= S_DOT;
                end
                S_DOT: begin
                    // Address k issues now; data of k-1 arrives in uf_rd.
                    if (r_dv) r_acc <= r_acc + 48'(prod);
                    r_p <= uf_rd;
                    r_q <= mf_rd;
                    r_dv <= (r_k < r_kk);
                    if (r_k < r_kk) begin
                        r_k <= r_k + 1'b1;
                    end else if (!r_dv) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (r_acc <= sum_pred_low()) r_pred <= PRED_LOW;
                    else if (r_acc >= sum_pred_high()) r_pred <= PRED_HIGH;
                    else r_pred <= r_acc[26:12];
                    if (r_train) begin
                        r_state <= S_UPD_MUL;
                        r_phase <= 2'd0;
                        r_clr <= '0;
                    end else begin
                        r_err <= '0;
                        r_state <= S_OUT;
                        m_axis_tvalid <= 1'b1;
                    end
                    r_k <= '0;
                end
                S_UPD_RD: begin
                    if (r_k < r_kk) begin
                        r_state <= S_UPD_WAIT;
                    end else begin
                        r_state <= S_OUT;
                        m_axis_tvalid <= 1'b1;
                    end
                end
                S_UPD_WAIT: begin
                    r_p <= uf_rd;
                    r_q <= mf_rd;
                    r_eq <= r_err * $signed(mf_rd);
                    r_ep <= r_err * $signed(uf_rd);
                    r_phase <= 2'd1;
                    r_clr <= '0;
                    r_state <= S_UPD_MUL;
                end
                S_UPD_MUL: begin
                    if (is_bias_phase && r_clr == '0) begin
                        r_err <= $signed({1'b0, r_rating}) - $signed({1'b0, r_pred});
                        r_clr <= CW'(1);
                    end else begin
                        // Two register stages inside the step units.
                        r_clr <= r_clr + 1'b1;
                        if (r_clr == CW'(3)) r_state <= S_UPD_WR;
                    end
                end
                S_UPD_WR: begin
                    if (!is_bias_phase) r_k <= r_k + 1'b1;
                    r_phase <= 2'd1;
                    r_clr <= '0;
                    r_state <= S_UPD_RD;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        m_axis_tvalid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tdata = {1'b0, r_err, r_pred};
    assign m_axis_tuser = r_train;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready) else $error("accept while busy");
    a_out_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_state == S_OUT)) else $error("result outside output state");
    a_pred_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_pred >= PRED_LOW && r_pred <= PRED_HIGH))
        else $error("prediction out of range");
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD_WR) |-> (r_k < r_kk || is_bias_phase))
        else $error("factor index past K");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the rating-update block with a scoreboard class.
`timescale 1ns / 1ps

module tb_top
    import mfsgd_pkg::*;
;

    localparam int NFAC = 32;
    localparam int NUSR = 4096;
    localparam int NMOV = 8192;

    typedef struct packed {
        logic [14:0]        pred;
        logic signed [15:0] err;
        logic               trained;
    } t_rating_result;

    class t_rating_scoreboard;
        logic signed [15:0] user_fac [NUSR*NFAC];
        logic signed [15:0] movie_fac [NMOV*NFAC];
        logic signed [15:0] user_b [NUSR];
        logic signed [15:0] movie_b [NMOV];
        logic [14:0] mean;
        logic [15:0] rate;
        logic [15:0] lambda;
        logic [5:0]  kuse;
        t_rating_result pending_q[$];
        int errors;

        function new();
            foreach (user_b[i]) user_b[i] = '0;
            foreach (movie_b[i]) movie_b[i] = '0;
            mean = '0;
            rate = LEARN_RATE_RST;
            lambda = REG_WEIGHT_RST;
            kuse = FACTORS_RST;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                REG_GLOBAL_MEAN: mean = data[14:0];
                REG_LEARN_RATE:  rate = data;
                REG_REG_WEIGHT:  lambda = data;
                REG_FACTORS:     kuse = data[5:0];
                default: ;
            endcase
        endfunction

        function logic signed [15:0] clip16(longint v);
            if (v > 32767) return 16'sh7FFF;
            if (v < -32768) return 16'sh8000;
            return v[15:0];
        endfunction

        function void note_item(logic [1:0] cmd, logic [11:0] u, logic [12:0] m,
                                logic [4:0] f, logic signed [15:0] val, logic [14:0] rtg);
            longint acc, pred, e, ub, mb, lr, lam, p, q;
            int kk;
            t_rating_result res;
            if (cmd == CMD_LOAD_USER) begin
                user_fac[u*NFAC+f] = val;
                return;
            end
            if (cmd == CMD_LOAD_MOVIE) begin
                movie_fac[m*NFAC+f] = val;
                return;
            end
            kk = (kuse > NFAC) ? NFAC : kuse;
            ub = user_b[u];
            mb = movie_b[m];
            acc = (longint'(mean) + ub + mb) * 4096;
            for (int k = 0; k < kk; k++)
                acc += longint'(user_fac[u*NFAC+k]) * longint'(movie_fac[m*NFAC+k]);
            if (acc <= longint'(PRED_LOW) * 4096) pred = PRED_LOW;
            else if (acc >= longint'(PRED_HIGH) * 4096) pred = PRED_HIGH;
            else pred = acc >>> 12;
            res.pred = pred[14:0];
            if (cmd == CMD_PREDICT) begin
                res.err = '0;
                res.trained = 1'b0;
                pending_q = {pending_q, res};
                return;
            end
            e = longint'(rtg) - pred;
            lr = rate;
            lam = lambda;
            user_b[u] = clip16(ub + ((lr * (e * 65536 - lam * ub)) >>> 32));
            movie_b[m] = clip16(mb + ((lr * (e * 65536 - lam * mb)) >>> 32));
            for (int k = 0; k < kk; k++) begin
                p = user_fac[u*NFAC+k];
                q = movie_fac[m*NFAC+k];
                user_fac[u*NFAC+k] = clip16(p + ((lr * (e * q * 16 - lam * p)) >>> 32));
                movie_fac[m*NFAC+k] = clip16(q + ((lr * (e * p * 16 - lam * q)) >>> 32));
            end
            res.err = e[15:0];
            res.trained = 1'b1;
            pending_q = {pending_q, res};
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [14:0] pred, logic signed [15:0] err, logic trained);
            t_rating_result exp_r;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected result pred=%0d err=%0d", pred, err));
                return;
            end
            exp_r = pending_q.pop_front();
            if (pred !== exp_r.pred)
                report($sformatf("prediction %0d, expected %0d", pred, exp_r.pred));
            if (err !== exp_r.err)
                report($sformatf("error %0d, expected %0d", err, exp_r.err));
            if (trained !== exp_r.trained)
                report($sformatf("was_training %0b, expected %0b", trained, exp_r.trained));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    int snd_idle = 38;
    int rcv_idle = 73;
    logic rx_hold = 1'b0;

    logic [11:0] user_pool [4] = '{12'd0, 12'd1, 12'd2, 12'd4095};
    logic [12:0] movie_pool [4] = '{13'd0, 13'd1, 13'd2, 13'd8191};

    t_rating_scoreboard sb = new();

    mf_sgd_rating_update uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(negedge i_clk)
        m_axis_tready <= !rx_hold && ($urandom_range(99) >= rcv_idle);

    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[14:0], m_axis_tdata[30:15], m_axis_tuser);

    task automatic send_item(logic [1:0] cmd, logic [11:0] u, logic [12:0] m,
                             logic [4:0] f, logic signed [15:0] val, logic [14:0] rtg);
        while ($urandom_range(99) < snd_idle) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata = {1'b0, rtg, val, f, m, u, cmd};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(cmd, u, m, f, val, rtg);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (90) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        i_cfg_index = idx;
        i_cfg_data = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_all(logic [15:0] mean, logic [15:0] lr, logic [15:0] lam,
                           logic [15:0] kval);
        write_reg(REG_GLOBAL_MEAN, mean);
        write_reg(REG_LEARN_RATE, lr);
        write_reg(REG_REG_WEIGHT, lam);
        write_reg(REG_FACTORS, kval);
    endtask

    function automatic logic signed [15:0] rand_factor();
        if ($urandom_range(99) < 85) return 16'($signed($urandom_range(4095)) - 2048);
        return 16'($urandom);
    endfunction

    function automatic logic [14:0] rand_rating();
        if ($urandom_range(99) < 90) return 15'($urandom_range(20480, 2048));
        return 15'($urandom);
    endfunction

    task automatic random_items(int count);
        int pick;
        int ui;
        int mi;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            ui = $urandom_range(3);
            mi = $urandom_range(3);
            if (pick < 12)
                send_item(CMD_LOAD_USER, user_pool[ui], 13'($urandom), 5'($urandom),
                          rand_factor(), 15'($urandom));
            else if (pick < 24)
                send_item(CMD_LOAD_MOVIE, 12'($urandom), movie_pool[mi], 5'($urandom),
                          rand_factor(), 15'($urandom));
            else if (pick < 30)
                send_item(2'($urandom_range(1)), 12'($urandom_range(4095, 4)),
                          13'($urandom_range(8190, 4)), 5'($urandom), 16'($urandom),
                          15'($urandom));
            else if (pick < 75)
                send_item(CMD_TRAIN, user_pool[ui], movie_pool[mi], 5'($urandom),
                          16'($urandom), rand_rating());
            else
                send_item(CMD_PREDICT, user_pool[ui], movie_pool[mi], 5'($urandom),
                          16'($urandom), 15'($urandom));
        end
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < 4; r++)
            for (int k = 0; k < NFAC; k++) begin
                send_item(CMD_LOAD_USER, user_pool[r], 13'd0, 5'(k), rand_factor(), 15'd0);
                send_item(CMD_LOAD_MOVIE, 12'd0, movie_pool[r], 5'(k), rand_factor(),
                          15'h7FFF);
            end
        send_item(CMD_LOAD_USER, 12'd4095, 13'd8191, 5'd31, 16'sh7FFF, 15'h7FFF);
        send_item(CMD_LOAD_MOVIE, 12'd4095, 13'd8191, 5'd31, 16'sh8000, 15'd0);
        send_item(CMD_PREDICT, 12'd0, 13'd0, 5'd0, 16'sd0, 15'd0);
        send_item(CMD_PREDICT, 12'd4095, 13'd8191, 5'd31, 16'shFFFF, 15'h7FFF);
        send_item(CMD_TRAIN, 12'd0, 13'd0, 5'd0, 16'sd0, 15'd2048);
        send_item(CMD_TRAIN, 12'd4095, 13'd8191, 5'd0, 16'sd0, 15'd20480);
        send_item(CMD_TRAIN, 12'd1, 13'd2, 5'd0, 16'sd0, 15'd0);
        send_item(CMD_TRAIN, 12'd2, 13'd1, 5'd0, 16'sd0, 15'h7FFF);
        send_item(CMD_PREDICT, 12'd2, 13'd1, 5'd0, 16'sd0, 15'd0);
        random_items(100);

        drain();
        set_all(16'd20480, 16'd65535, 16'd0, 16'd1);
        fork
            begin
                rx_hold = 1'b1;
                repeat (600) @(negedge i_clk);
                rx_hold = 1'b0;
            end
        join_none
        random_items(100);

        drain();
        snd_idle = 73;
        rcv_idle = 38;
        set_all(16'd14000, 16'd0, 16'd65535, 16'd0);
        random_items(80);

        drain();
        set_all(16'd14500, 16'd2000, 16'd500, 16'd63);
        random_items(80);

        drain();
        snd_idle = 0;
        rcv_idle = 0;
        set_all(16'd0, 16'd328, 16'd1311, 16'd16);
        random_items(100);

        drain();
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #8000000;
        $display("FAIL");
        $finish;
    end

endmodule
